>>> hw/rtl/gclk_pkg.sv
// Shared types and constants for the gauge clock controller.
package gclk_pkg;

  localparam int NumButtons = 6;

  // Button bit positions within a sample
  localparam int BtnSecZero = 0;
  localparam int BtnMinUp   = 1;
  localparam int BtnMinDown = 2;
  localparam int BtnHrUp    = 3;
  localparam int BtnHrDown  = 4;
  localparam int BtnMode    = 5;

  // Item kinds carried on the input tuser
  localparam logic ModeTick   = 1'b0;
  localparam logic ModeSample = 1'b1;

  // Configuration register indexes
  localparam int CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgFirstDelay   = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgRepeatPeriod = 1'b1;

  localparam logic [7:0] FirstDelayReset   = 8'd60;
  localparam logic [7:0] RepeatPeriodReset = 8'd10;

  // Time-of-day limits
  localparam logic [5:0] LastSecond  = 6'd59;
  localparam logic [5:0] LastMinute  = 6'd59;
  localparam logic [7:0] MinuteWrap  = 8'd59;
  localparam logic [3:0] FirstHour   = 4'd1;
  localparam logic [3:0] LastHour    = 4'd12;
  localparam logic [7:0] HourWrap    = 8'd13;

  // Calibration level limits
  localparam logic [7:0] CalibMax  = 8'd240;
  localparam logic [7:0] CalibStep = 8'd4;

  typedef struct packed {
    logic       mode;
    logic [5:0] buttons;
  } item_t;

  typedef struct packed {
    logic       calibrating;
    logic       afternoon;
    logic [7:0] hours_drive;
    logic [7:0] minutes_drive;
    logic [7:0] seconds_drive;
  } result_t;

endpackage

>>> hw/rtl/gclk_repeat.sv
// Per-button auto-repeat: held flags and repeat countdowns for six buttons.
module gclk_repeat (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           step,
  input  logic [gclk_pkg::NumButtons-1:0] buttons,
  input  logic [7:0]                     first_delay,
  input  logic [7:0]                     period,
  output logic                           fired
);
  import gclk_pkg::*;

  logic [NumButtons-1:0] held;
  logic [NumButtons-1:0] held_next;
  logic [7:0]            countdown      [NumButtons];
  logic [7:0]            countdown_next [NumButtons];
  logic [NumButtons-1:0] fire_lane;

  // Work out each lane's next countdown and whether it fires
  always_comb begin
    for (int i = 0; i < NumButtons; i++) begin
      logic [7:0] dec;
      dec = countdown[i] - 8'd1;
      held_next[i]      = buttons[i];
      countdown_next[i] = countdown[i];
      fire_lane[i]      = 1'b0;
      if (buttons[i] && !held[i]) begin
        countdown_next[i] = first_delay;
        fire_lane[i]      = 1'b1;
      end else if (buttons[i]) begin
        if (dec == 8'd0) begin
          countdown_next[i] = period;
          fire_lane[i]      = 1'b1;
        end else begin
          countdown_next[i] = dec;
        end
      end
    end
  end

  assign fired = |fire_lane;

  // Hold held flags; countdowns need no reset as a fresh press reloads them
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (step) begin
      held <= held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      for (int i = 0; i < NumButtons; i++) begin
        countdown[i] <= countdown_next[i];
      end
    end
  end

endmodule

>>> hw/rtl/gclk_time.sv
// Time-of-day counters, calibration level and gauge drive calculation.
module gclk_time (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            step,
  input  gclk_pkg::item_t                 item,
  input  logic                            fired,
  output logic                            res_valid,
  output gclk_pkg::result_t               result
);
  import gclk_pkg::*;

  logic [5:0] sec,  sec_next;
  logic [5:0] min,  min_next;
  logic [3:0] hour, hour_next;
  logic       half, half_next;
  logic [7:0] calib, calib_next;

  logic [7:0] min_up, min_dn, hr_up, hr_dn, cal_up, cal_dn;
  logic [5:0] min_plus1;
  logic [7:0] hour_w;
  logic       calib_mode;

  assign calib_mode = item.buttons[BtnMode];
  assign min_up = {2'b00, min} + 8'd1;
  assign min_dn = {2'b00, min} - 8'd1;
  assign hr_up  = {4'b0000, hour} + 8'd1;
  assign hr_dn  = {4'b0000, hour} - 8'd1;
  assign cal_up = calib + CalibStep;
  assign cal_dn = calib - CalibStep;

  // Next state for a tick or a button sample
  always_comb begin
    sec_next   = sec;
    min_next   = min;
    hour_next  = hour;
    half_next  = half;
    calib_next = calib;
    res_valid  = 1'b0;
    if (step && item.mode == ModeTick) begin
      // Advance the clock with carries
      if (sec == LastSecond) begin
        sec_next = '0;
        if (min == LastMinute) begin
          min_next = '0;
          if (hour == LastHour) begin
            hour_next = FirstHour;
            half_next = ~half;
          end else begin
            hour_next = hour + 4'd1;
          end
        end else begin
          min_next = min + 6'd1;
        end
      end else begin
        sec_next = sec + 6'd1;
      end
    end else if (step && calib_mode) begin
      // Step or toggle the shared calibration level
      if (fired) begin
        priority if (item.buttons[BtnSecZero]) begin
          calib_next = (calib != 8'd0) ? 8'd0 : CalibMax;
        end else if (item.buttons[BtnMinDown] || item.buttons[BtnHrDown]) begin
          if (calib == 8'd0) calib_next = CalibMax;
          else calib_next = (cal_dn >= CalibMax) ? 8'd0 : cal_dn;
        end else if (item.buttons[BtnMinUp] || item.buttons[BtnHrUp]) begin
          calib_next = (cal_up >= CalibMax) ? 8'd0 : cal_up;
        end else begin
          calib_next = calib;
        end
      end
      res_valid = (calib_next != calib);
    end else if (step) begin
      // Apply run-mode buttons
      if (fired) begin
        if (item.buttons[BtnSecZero]) sec_next = '0;
        if (item.buttons[BtnMinUp]) begin
          min_next = (min_up >= MinuteWrap) ? 6'd0 : min_up[5:0];
        end else if (item.buttons[BtnMinDown]) begin
          if (min == 6'd0) min_next = LastMinute;
          else min_next = (min_dn >= MinuteWrap) ? 6'd0 : min_dn[5:0];
        end
        if (item.buttons[BtnHrUp]) begin
          hour_next = (hr_up >= HourWrap) ? FirstHour : hr_up[3:0];
        end else if (item.buttons[BtnHrDown]) begin
          if (hour == FirstHour) hour_next = LastHour;
          else hour_next = (hr_dn >= HourWrap) ? FirstHour : hr_dn[3:0];
        end
      end
      res_valid = 1'b1;
    end
  end

  // Form gauge drives from the updated state
  assign min_plus1 = min_next + 6'd1;
  assign hour_w    = {4'b0000, hour_next};

  always_comb begin
    result.afternoon   = half_next;
    result.calibrating = calib_mode;
    if (calib_mode) begin
      result.seconds_drive = calib_next;
      result.minutes_drive = calib_next;
      result.hours_drive   = calib_next;
    end else begin
      result.seconds_drive = {sec_next, 2'b00};
      result.minutes_drive = {min_plus1, 2'b00};
      result.hours_drive   = (hour_w << 4) + (hour_w << 2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sec   <= '0;
      min   <= '0;
      hour  <= FirstHour;
      half  <= 1'b0;
      calib <= '0;
    end else begin
      sec   <= sec_next;
      min   <= min_next;
      hour  <= hour_next;
      half  <= half_next;
      calib <= calib_next;
    end
  end

endmodule

>>> hw/rtl/gauge_clock_controller.sv
// Gauge clock controller top level: input register, update logic, result register.
// A result beat is registered in the input register and then in the result
// register; a tick or an unchanged level gives none.
// Throughput: one beat per cycle; the input register feeds the clock and
// auto-repeat update combinationally, so only a stalled result holds input.
// Reset (rst, synchronous): time 1:00:00 am, calibration 0, all buttons
// released, repeat delay 60 and period 10, both registers empty.
module gauge_clock_controller (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,  // [5:0] buttons
  input  logic                           s_axis_tuser,  // [0] mode
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [31:0]                    m_axis_tdata,  // [7:0] seconds_drive,
                                                        // [15:8] minutes_drive,
                                                        // [23:16] hours_drive,
                                                        // [24] afternoon
  output logic                           m_axis_tuser,  // [0] calibrating
  input  logic                           cfg_we,
  input  logic [gclk_pkg::CfgIdxW-1:0]   cfg_addr,
  input  logic [7:0]                     cfg_data
);
  import gclk_pkg::*;

  logic       s1_valid;
  item_t      s1_item;
  logic       s1_adv;
  logic       in_beat;
  logic [7:0] first_delay;
  logic [7:0] period;
  logic       step;
  logic       sample_step;
  logic       fired;
  logic       res_valid;
  result_t    res;
  result_t    out_res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      first_delay <= FirstDelayReset;
      period      <= RepeatPeriodReset;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CfgFirstDelay:   first_delay <= cfg_data;
        CfgRepeatPeriod: period      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register advances whenever the result register can take a beat
  assign s1_adv        = s1_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !s1_valid || s1_adv;
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign step          = s1_adv;
  assign sample_step   = s1_adv && (s1_item.mode == ModeSample);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_beat) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      s1_item.mode    <= s_axis_tuser;
      s1_item.buttons <= s_axis_tdata[NumButtons-1:0];
    end
  end

  gclk_repeat u_repeat (
    .clk         (clk),
    .rst         (rst),
    .step        (sample_step),
    .buttons     (s1_item.buttons),
    .first_delay (first_delay),
    .period      (period),
    .fired       (fired)
  );

  gclk_time u_time (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .item      (s1_item),
    .fired     (fired),
    .res_valid (res_valid),
    .result    (res)
  );

  // Result register: load a new beat or drop the one taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s1_adv && res_valid) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && res_valid) begin
      out_res <= res;
    end
  end

  assign m_axis_tdata = {7'b0000000, out_res.afternoon, out_res.hours_drive,
                         out_res.minutes_drive, out_res.seconds_drive};
  assign m_axis_tuser = out_res.calibrating;

  // A calibration result drives all three gauges alike
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |->
      m_axis_tdata[7:0] == m_axis_tdata[15:8] &&
      m_axis_tdata[15:8] == m_axis_tdata[23:16])
    else $error("calibration drives differ");

  // Drives never exceed full scale
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      m_axis_tdata[7:0] <= CalibMax && m_axis_tdata[15:8] <= CalibMax &&
      m_axis_tdata[23:16] <= CalibMax)
    else $error("gauge drive above full scale");

  // A run result always shows nonzero hour and minute drives
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |->
      m_axis_tdata[23:16] != 8'd0 && m_axis_tdata[15:8] != 8'd0)
    else $error("run result with zero hour or minute drive");

  // A tick never produces a result beat
  assert property (@(posedge clk) disable iff (rst)
    s1_adv && s1_item.mode == ModeTick |-> !res_valid)
    else $error("tick produced a result");

endmodule
